// File: rtl/xxh64_pkg.sv
// xxh64_pkg: constants, sequencer states and helpers for the xxHash64 unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xxh64_pkg;
  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RND_A,   // acc + w*P2
    S_RND_B,   // rotl31 * P1
    S_FIN_SUM,
    S_MRG_A,   // lane*P2
    S_MRG_B,   // rotl31*P1, xor into h
    S_MRG_C,   // h*P1 + P4
    S_LEN,
    S_MIX_A,
    S_MIX_B,
    S_MIX_C,   // rotl27(h)*P1 + P4
    S_T4_A,
    S_T4_B,    // rotl23(h)*P2 + P3
    S_T1_A,
    S_T1_B,    // rotl11(h)*P1
    S_AV1,
    S_AV2,
    S_OUT
  } state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] d;
    d = {x, x} << r;
    return d[127:64];
  endfunction
endpackage
`default_nettype wire

// File: rtl/xxhash64_stream_hasher_unit.sv
// xxhash64_stream_hasher_unit: xxHash64 of a word stream on one shared 32x32 multiplier
// under a sequencer; each 64-bit product (low half) is built from 32-bit partial
// products. Depends on xxh64_pkg. A word that completes a stripe runs the lane rounds
// before the next word is accepted. The hash is held until taken; no word is accepted
// from the last word until then. Synchronous active-high reset clears control, the
// seed register and the length count.
`timescale 1ns / 1ps
`default_nettype none
module xxhash64_stream_hasher_unit #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] hash_seed,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] message_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      hash_value
);
  xxh64_pkg::state_t state, state_next;
  logic [63:0] seed_reg, msg_seed;
  logic [63:0] lanes [4];
  logic [63:0] stripe [3];
  logic [1:0]  fill;
  logic [LENGTH_BITS-1:0] msg_len, len_sum;
  logic        active;
  logic [63:0] h, acc, wreg, prod;
  logic [63:0] acc_tail;
  logic [63:0] mul_a, mul_b;
  logic        mul_busy, step;
  logic [1:0]  mph;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mop_p;
  logic [63:0] mul_lo;
  logic [31:0] mul_x;
  logic [1:0]  idx;
  logic [3:0]  cnt;
  logic [3:0]  cnt_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == xxh64_pkg::S_IDLE) && !out_valid;
  assign cnt_sat   = last ? ((byte_count > 4'd8) ? 4'd8 : byte_count) : 4'd8;

  always_comb begin
    mul_a = acc;
    mul_b = xxh64_pkg::P1;
    mul_busy = 1'b1;
    unique case (state)
      xxh64_pkg::S_IDLE, xxh64_pkg::S_FIN_SUM, xxh64_pkg::S_LEN, xxh64_pkg::S_OUT:
        mul_busy = 1'b0;
      xxh64_pkg::S_RND_A, xxh64_pkg::S_MRG_A, xxh64_pkg::S_MIX_A: begin
        mul_a = wreg; mul_b = xxh64_pkg::P2;
      end
      xxh64_pkg::S_RND_B, xxh64_pkg::S_MRG_B, xxh64_pkg::S_MIX_B: begin
        mul_a = xxh64_pkg::rotl(acc, 6'd31);
      end
      xxh64_pkg::S_MRG_C: mul_a = h;
      xxh64_pkg::S_MIX_C: mul_a = xxh64_pkg::rotl(h, 6'd27);
      xxh64_pkg::S_T4_A: mul_a = {32'd0, wreg[31:0]};
      xxh64_pkg::S_T4_B: begin mul_a = xxh64_pkg::rotl(h, 6'd23); mul_b = xxh64_pkg::P2; end
      xxh64_pkg::S_T1_A: begin mul_a = {56'd0, wreg[7:0]}; mul_b = xxh64_pkg::P5; end
      xxh64_pkg::S_T1_B: mul_a = xxh64_pkg::rotl(h, 6'd11);
      xxh64_pkg::S_AV1: begin mul_a = h ^ (h >> 33); mul_b = xxh64_pkg::P2; end
      xxh64_pkg::S_AV2: begin mul_a = h ^ (h >> 29); mul_b = xxh64_pkg::P3; end
      default: ;
    endcase
  end

  // low 64 bits of mul_a*mul_b: lo*lo, then the two cross terms
  always_comb begin
    unique case (mph)
      2'd0: begin mop_a = mul_a[31:0]; mop_b = mul_b[31:0]; end
      2'd1: begin mop_a = mul_a[31:0]; mop_b = mul_b[63:32]; end
      default: begin mop_a = mul_a[63:32]; mop_b = mul_b[31:0]; end
    endcase
  end
  assign mop_p = 64'(mop_a) * 64'(mop_b);
  assign prod  = mul_lo + {mul_x + mop_p[31:0], 32'd0};
  assign step  = !mul_busy || (mph == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      mph <= 2'd0;
    end else begin
      mph <= step ? 2'd0 : mph + 2'd1;
      if (mph == 2'd0) mul_lo <= mop_p;
      if (mph == 2'd1) mul_x <= mop_p[31:0];
    end
  end

  // after the length step / last stripe mix, pick next phase
  function automatic xxh64_pkg::state_t after_words(input logic [3:0] c);
    if (c >= 4'd4) return xxh64_pkg::S_T4_A;
    if (c != 4'd0) return xxh64_pkg::S_T1_A;
    return xxh64_pkg::S_AV1;
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      xxh64_pkg::S_IDLE: ;
      xxh64_pkg::S_RND_A: state_next = xxh64_pkg::S_RND_B;
      xxh64_pkg::S_RND_B: state_next = (idx == 2'd3) ?
          (cnt[3] ? xxh64_pkg::S_IDLE : xxh64_pkg::S_FIN_SUM) : xxh64_pkg::S_RND_A;
      xxh64_pkg::S_FIN_SUM: state_next = (msg_len >= LENGTH_BITS'(32)) ?
          xxh64_pkg::S_MRG_A : xxh64_pkg::S_LEN;
      xxh64_pkg::S_MRG_A: state_next = xxh64_pkg::S_MRG_B;
      xxh64_pkg::S_MRG_B: state_next = xxh64_pkg::S_MRG_C;
      xxh64_pkg::S_MRG_C: state_next = (idx == 2'd3) ? xxh64_pkg::S_LEN : xxh64_pkg::S_MRG_A;
      xxh64_pkg::S_LEN: state_next = (fill != 2'd0) ? xxh64_pkg::S_MIX_A : after_words(cnt);
      xxh64_pkg::S_MIX_A: state_next = xxh64_pkg::S_MIX_B;
      xxh64_pkg::S_MIX_B: state_next = xxh64_pkg::S_MIX_C;
      xxh64_pkg::S_MIX_C: state_next = (idx + 2'd1 == fill) ?
          after_words(cnt) : xxh64_pkg::S_MIX_A;
      xxh64_pkg::S_T4_A: state_next = xxh64_pkg::S_T4_B;
      xxh64_pkg::S_T4_B: state_next = (cnt != 4'd4) ? xxh64_pkg::S_T1_A : xxh64_pkg::S_AV1;
      xxh64_pkg::S_T1_A: state_next = xxh64_pkg::S_T1_B;
      xxh64_pkg::S_T1_B: state_next = (cnt != 4'd1) ? xxh64_pkg::S_T1_A : xxh64_pkg::S_AV1;
      xxh64_pkg::S_AV1: state_next = xxh64_pkg::S_AV2;
      xxh64_pkg::S_AV2: state_next = xxh64_pkg::S_OUT;
      xxh64_pkg::S_OUT: state_next = xxh64_pkg::S_IDLE;
      default: state_next = xxh64_pkg::S_IDLE;
    endcase
    if (state == xxh64_pkg::S_IDLE && in_valid && in_ready) begin
      if (fill == 2'd3 && cnt_sat == 4'd8 && active) state_next = xxh64_pkg::S_RND_A;
      else if (last) state_next = xxh64_pkg::S_FIN_SUM;
    end
    if (!step) state_next = state;
  end

  assign len_sum = (active ? msg_len : '0) + LENGTH_BITS'(cnt_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xxh64_pkg::S_IDLE;
      seed_reg <= '0;
      msg_seed <= '0;
      active <= 1'b0;
      fill <= 2'd0;
      msg_len <= '0;
      out_valid <= 1'b0;
      idx <= 2'd0;
      cnt <= 4'd0;
      lanes[0] <= xxh64_pkg::P1 + xxh64_pkg::P2;
      lanes[1] <= xxh64_pkg::P2;
      lanes[2] <= '0;
      lanes[3] <= -xxh64_pkg::P1;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) seed_reg <= hash_seed;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (step) begin
        unique case (state)
          xxh64_pkg::S_IDLE: if (in_valid && in_ready) begin
            msg_len <= len_sum;
            acc_tail <= message_word;
            active <= !last;
            if (!active) begin
              msg_seed <= seed_reg;
              lanes[0] <= seed_reg + xxh64_pkg::P1 + xxh64_pkg::P2;
              lanes[1] <= seed_reg + xxh64_pkg::P2;
              lanes[2] <= seed_reg;
              lanes[3] <= seed_reg - xxh64_pkg::P1;
            end
            idx <= 2'd0;
            if (cnt_sat == 4'd8) begin
              cnt <= last ? 4'd0 : 4'd8;
              if (active && fill == 2'd3) begin
                wreg <= stripe[0];
                h <= message_word; // lane 3 word kept apart
                fill <= 2'd0;
              end else begin
                wreg <= message_word;
                stripe[active ? fill : 2'd0] <= message_word;
                fill <= active ? fill + 2'd1 : 2'd1;
              end
            end else begin
              cnt <= cnt_sat;
              wreg <= message_word;
              if (!active) fill <= 2'd0;
            end
          end
          xxh64_pkg::S_RND_A: acc <= lanes[idx] + prod;
          xxh64_pkg::S_RND_B: begin
            lanes[idx] <= prod;
            idx <= idx + 2'd1;
            wreg <= (idx == 2'd2) ? h : stripe[idx + 2'd1];
          end
          xxh64_pkg::S_FIN_SUM: begin
            idx <= 2'd0;
            h <= (msg_len >= LENGTH_BITS'(32)) ?
                 xxh64_pkg::rotl(lanes[0], 6'd1) + xxh64_pkg::rotl(lanes[1], 6'd7) +
                 xxh64_pkg::rotl(lanes[2], 6'd12) + xxh64_pkg::rotl(lanes[3], 6'd18) :
                 msg_seed + xxh64_pkg::P5;
            wreg <= lanes[0];
            acc <= wreg;
          end
          xxh64_pkg::S_MRG_A: acc <= prod;
          xxh64_pkg::S_MRG_B: h <= h ^ prod;
          xxh64_pkg::S_MRG_C: begin
            h <= prod + xxh64_pkg::P4;
            idx <= idx + 2'd1;
            wreg <= lanes[idx + 2'd1];
          end
          xxh64_pkg::S_LEN: begin
            h <= h + 64'(msg_len);
            idx <= 2'd0;
            wreg <= (fill != 2'd0) ? stripe[0] : acc_tail;
          end
          xxh64_pkg::S_MIX_A: acc <= prod;
          xxh64_pkg::S_MIX_B: h <= h ^ prod;
          xxh64_pkg::S_MIX_C: begin
            h <= prod + xxh64_pkg::P4;
            idx <= idx + 2'd1;
            wreg <= (idx + 2'd1 == fill) ? acc_tail : stripe[idx + 2'd1];
          end
          xxh64_pkg::S_T4_A: h <= h ^ prod;
          xxh64_pkg::S_T4_B: begin
            h <= prod + xxh64_pkg::P3;
            wreg <= wreg >> 32;
            cnt <= cnt - 4'd4;
          end
          xxh64_pkg::S_T1_A: h <= h ^ prod;
          xxh64_pkg::S_T1_B: begin
            h <= prod;
            wreg <= wreg >> 8;
            cnt <= cnt - 4'd1;
          end
          xxh64_pkg::S_AV1: h <= prod;
          xxh64_pkg::S_AV2: h <= prod;
          xxh64_pkg::S_OUT: begin
            hash_value <= h ^ (h >> 32);
            out_valid <= 1'b1;
            fill <= 2'd0;
            msg_len <= '0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value));
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != xxh64_pkg::S_IDLE |-> !in_ready);
  a_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready);
  a_mul_phase: assert property (@(posedge clk) disable iff (rst) mph != 2'd3);
`endif
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// tb_top: self-checking bench for xxhash64_stream_hasher_unit.
// Drives message words and seed writes, predicts each hash, and checks results.
// Depends on xxh64_pkg and the unit RTL.
`timescale 1ns / 1ps
`default_nettype none

class hash_scoreboard;
  logic [63:0] seed_reg;
  logic [63:0] msg_seed;
  logic [63:0] lane[4];
  logic [63:0] stripe[3];
  int unsigned fill;
  logic [63:0] msg_len;
  bit active;
  logic [63:0] pending_hash[$];
  int errors;

  function new();
    seed_reg = '0;
    active = 0;
    fill = 0;
    msg_len = '0;
    errors = 0;
  endfunction

  function logic [63:0] rol(logic [63:0] x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function logic [63:0] lane_rnd(logic [63:0] acc, logic [63:0] w);
    acc = acc + w * xxh64_pkg::P2;
    return rol(acc, 31) * xxh64_pkg::P1;
  endfunction

  function void start_msg();
    msg_seed = seed_reg;
    lane[0] = msg_seed + xxh64_pkg::P1 + xxh64_pkg::P2;
    lane[1] = msg_seed + xxh64_pkg::P2;
    lane[2] = msg_seed;
    lane[3] = msg_seed - xxh64_pkg::P1;
    fill = 0;
    msg_len = '0;
    active = 1;
  endfunction

  function void absorb(logic [63:0] w);
    if (fill < 3) begin
      stripe[fill] = w;
      fill++;
    end else begin
      for (int i = 0; i < 3; i++) lane[i] = lane_rnd(lane[i], stripe[i]);
      lane[3] = lane_rnd(lane[3], w);
      fill = 0;
    end
  endfunction

  function void note_word(logic [63:0] w, logic [3:0] cnt_in, logic is_last);
    logic [63:0] h;
    int cnt;
    if (!active) start_msg();
    if (!is_last) begin
      msg_len += 8;
      absorb(w);
      return;
    end
    cnt = (cnt_in > 8) ? 8 : cnt_in;
    msg_len += cnt;
    if (cnt == 8) begin
      absorb(w);
      cnt = 0;
    end
    if (msg_len >= 32) begin
      h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
      for (int i = 0; i < 4; i++) begin
        h ^= lane_rnd(0, lane[i]);
        h = h * xxh64_pkg::P1 + xxh64_pkg::P4;
      end
    end else begin
      h = msg_seed + xxh64_pkg::P5;
    end
    h += msg_len;
    for (int i = 0; i < fill; i++) begin
      h ^= lane_rnd(0, stripe[i]);
      h = rol(h, 27) * xxh64_pkg::P1 + xxh64_pkg::P4;
    end
    if (cnt >= 4) begin
      h ^= {32'd0, w[31:0]} * xxh64_pkg::P1;
      h = rol(h, 23) * xxh64_pkg::P2 + xxh64_pkg::P3;
      w = w >> 32;
      cnt -= 4;
    end
    while (cnt > 0) begin
      h ^= {56'd0, w[7:0]} * xxh64_pkg::P5;
      h = rol(h, 11) * xxh64_pkg::P1;
      w = w >> 8;
      cnt--;
    end
    h ^= h >> 33;
    h *= xxh64_pkg::P2;
    h ^= h >> 29;
    h *= xxh64_pkg::P3;
    h ^= h >> 32;
    pending_hash.push_back(h);
    active = 0;
    fill = 0;
    msg_len = '0;
  endfunction

  function void report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endfunction

  function void check_hash(logic [63:0] got);
    logic [63:0] want;
    if (pending_hash.size() == 0) begin
      report_mismatch($sformatf("unexpected hash %h", got));
      return;
    end
    want = pending_hash.pop_front();
    if (got !== want) report_mismatch($sformatf("hash_value %h, want %h", got, want));
  endfunction
endclass

module tb_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [63:0] hash_seed = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [63:0] message_word = '0;
  logic [3:0]  byte_count = '0;
  logic        last = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [63:0] hash_value;

  int src_idle_pct;
  int snk_idle_pct;
  int words_sent;
  hash_scoreboard sb;

  always #6 clk = ~clk;

  xxhash64_stream_hasher_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .hash_seed(hash_seed),
    .in_valid(in_valid), .in_ready(in_ready),
    .message_word(message_word), .byte_count(byte_count), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .hash_value(hash_value)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_hash(hash_value);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_word(logic [63:0] w, logic [3:0] cnt, logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    message_word <= w;
    byte_count <= cnt;
    last <= is_last;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w, cnt, is_last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_msg(int full_words, logic [3:0] tail_cnt);
    for (int i = 0; i < full_words; i++)
      send_word(rand64(), ($urandom_range(1) ? 4'd8 : 4'($urandom_range(15))), 1'b0);
    send_word(rand64(), tail_cnt, 1'b1);
  endtask

  task automatic write_seed(logic [63:0] s);
    in_valid <= 0;
    while (sb.pending_hash.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_valid <= 1;
    hash_seed <= s;
    do @(posedge clk); while (!cfg_ready);
    sb.seed_reg = s;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_msg();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 7);
    send_msg(n, 4'($urandom_range(15)));
  endtask

  initial begin
    sb = new();
    src_idle_pct = 23;
    snk_idle_pct = 75;
    words_sent = 0;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: empty, tail counts 0 to 8 and 15, stripe edges, max fields
    send_msg(0, 4'd0);
    send_word('1, 4'd15, 1'b1);
    for (int c = 1; c <= 8; c++) send_msg(0, 4'(c));
    send_msg(3, 4'd8);
    send_msg(4, 4'd0);
    send_msg(4, 4'd5);
    send_word(64'h0, 4'd0, 1'b0);
    send_word('1, 4'd15, 1'b0);
    send_word(64'hA5A5A5A5A5A5A5A5, 4'd8, 1'b0);
    send_word(64'h5A5A5A5A5A5A5A5A, 4'd3, 1'b1);
    write_seed('1);
    send_msg(0, 4'd0);
    send_msg(5, 4'd7);
    write_seed(64'h0);
    send_msg(2, 4'd4);
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 75 : 0;
      snk_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 23 : 0;
      write_seed(rand64());
      while (words_sent < 60 + (phase + 1) * 200) random_msg();
    end
    in_valid <= 0;
    while (sb.pending_hash.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/xxh64_pkg.sv
rtl/xxhash64_stream_hasher_unit.sv
sim/tb_top.sv
